FILE: rtl/i2cm_pkg.sv
// Package for the I2C register-access master.
// Holds the item structs, the phase encoding and the named codes.
// No dependencies.
package i2cm_pkg;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] write_value;
        logic       sda_in;
    } t_in_item;

    typedef struct packed {
        logic       scl;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       ack_error;
    } t_out_item;

    typedef struct packed {
        logic [6:0] device_address;
        logic [7:0] register_address;
    } t_cfg;

    typedef enum logic [14:0] {
        PH_IDLE      = 15'b000000000000001,
        PH_BIT_LOW   = 15'b000000000000010,
        PH_BIT_HIGH  = 15'b000000000000100,
        PH_ACK_LOW   = 15'b000000000001000,
        PH_ACK_HIGH  = 15'b000000000010000,
        PH_RS_LOW    = 15'b000000000100000,
        PH_RS_HIGH   = 15'b000000001000000,
        PH_RS_FALL   = 15'b000000010000000,
        PH_RD_LOW    = 15'b000000100000000,
        PH_RD_HIGH   = 15'b000001000000000,
        PH_NACK_LOW  = 15'b000010000000000,
        PH_NACK_HIGH = 15'b000100000000000,
        PH_STOP_LOW  = 15'b001000000000000,
        PH_STOP_HIGH = 15'b010000000000000,
        PH_STOP_DONE = 15'b100000000000000
    } t_phase;

    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [1:0] BYTE_DEV   = 2'd0;
    localparam logic [1:0] BYTE_REG   = 2'd1;
    localparam logic [1:0] BYTE_DATA  = 2'd2;
    localparam logic [1:0] BYTE_RADDR = 2'd3;

    localparam logic CFG_DEVICE_ADDRESS   = 1'b0;
    localparam logic CFG_REGISTER_ADDRESS = 1'b1;

    localparam logic [6:0] DEV_ADDR_RESET = 7'd62;
    localparam logic [7:0] REG_ADDR_RESET = 8'd0;

    localparam logic [2:0] LAST_BIT = 3'd7;

endpackage

FILE: rtl/i2c_master_register_access.sv
// Top level of the I2C register-access master: one half-bit tick per item.
// Latency: a result is valid in the cycle after its item is accepted.
// Throughput: one item per cycle; the result register stalls input only while it is full
// and the output side is not ready.
// Reset (synchronous, active low) puts the bus idle, empties the result register and loads
// device address 62 and register address 0. Depends on i2cm_pkg and the i2cm_* modules.
module i2c_master_register_access (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  i2cm_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output i2cm_pkg::t_out_item o_out_item,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [7:0]          i_cfg_wdata
);
    import i2cm_pkg::*;

    t_cfg      cfg;
    t_out_item result;
    logic      can_load;
    logic      accept;

    assign accept     = i_in_valid && can_load;
    assign o_in_ready = can_load;

    i2cm_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    i2cm_fsm u_fsm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (accept),
        .i_item   (i_in_item),
        .i_cfg    (cfg),
        .o_result (result)
    );

    i2cm_out_stage u_out_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (accept),
        .i_result    (result),
        .o_can_load  (can_load),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

FILE: rtl/i2cm_cfg_regs.sv
// Configuration registers of the I2C register-access master.
// Depends on i2cm_pkg for the register indexes and the t_cfg struct.
module i2cm_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_index,
    input  logic [7:0]    i_cfg_wdata,
    output i2cm_pkg::t_cfg o_cfg
);
    import i2cm_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.device_address   <= DEV_ADDR_RESET;
            r_cfg.register_address <= REG_ADDR_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_DEVICE_ADDRESS) begin
                r_cfg.device_address <= i_cfg_wdata[6:0];
            end else begin
                r_cfg.register_address <= i_cfg_wdata;
            end
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: rtl/i2cm_fsm.sv
// Bus sequencer of the I2C register-access master: one transition per tick item.
// Depends on i2cm_pkg for the phase encoding, the codes and the item structs.
module i2cm_fsm (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  i2cm_pkg::t_in_item i_item,
    input  i2cm_pkg::t_cfg     i_cfg,
    output i2cm_pkg::t_out_item o_result
);
    import i2cm_pkg::*;

    t_phase     r_phase, n_phase;
    logic [2:0] r_bit_count, n_bit_count;
    logic [1:0] r_byte_index, n_byte_index;
    logic [7:0] r_shift_byte, n_shift_byte;
    logic [7:0] r_received_byte, n_received_byte;
    logic       r_read_mode, n_read_mode;
    logic       r_ack_fault, n_ack_fault;
    logic [7:0] r_data_byte, n_data_byte;

    logic       out_bit;
    logic       scl;
    logic       sda;
    logic       busy;
    logic       done;

    assign out_bit = r_shift_byte[LAST_BIT - r_bit_count];

    always_comb begin
        n_phase         = r_phase;
        n_bit_count     = r_bit_count;
        n_byte_index    = r_byte_index;
        n_shift_byte    = r_shift_byte;
        n_received_byte = r_received_byte;
        n_read_mode     = r_read_mode;
        n_ack_fault     = r_ack_fault;
        n_data_byte     = r_data_byte;
        scl  = 1'b1;
        sda  = 1'b1;
        busy = 1'b1;
        done = 1'b0;
        unique case (r_phase)
            PH_IDLE: begin
                if (i_item.cmd == CMD_WRITE || i_item.cmd == CMD_READ) begin
                    n_read_mode  = (i_item.cmd == CMD_READ);
                    n_data_byte  = i_item.write_value;
                    n_ack_fault  = 1'b0;
                    n_byte_index = BYTE_DEV;
                    n_bit_count  = 3'd0;
                    n_shift_byte = {i_cfg.device_address, 1'b0};
                    sda          = 1'b0;
                    n_phase      = PH_BIT_LOW;
                end else begin
                    busy = 1'b0;
                end
            end
            PH_BIT_LOW: begin
                scl     = 1'b0;
                sda     = out_bit;
                n_phase = PH_BIT_HIGH;
            end
            PH_BIT_HIGH: begin
                sda = out_bit;
                if (r_bit_count == LAST_BIT) begin
                    n_bit_count = 3'd0;
                    n_phase     = PH_ACK_LOW;
                end else begin
                    n_bit_count = r_bit_count + 3'd1;
                    n_phase     = PH_BIT_LOW;
                end
            end
            PH_ACK_LOW: begin
                scl     = 1'b0;
                n_phase = PH_ACK_HIGH;
            end
            PH_ACK_HIGH: begin
                if (i_item.sda_in) begin
                    n_ack_fault = 1'b1;
                end
                n_bit_count = 3'd0;
                unique case (r_byte_index)
                    BYTE_DEV: begin
                        n_byte_index = BYTE_REG;
                        n_shift_byte = i_cfg.register_address;
                        n_phase      = PH_BIT_LOW;
                    end
                    BYTE_REG: begin
                        if (r_read_mode) begin
                            n_phase = PH_RS_LOW;
                        end else begin
                            n_byte_index = BYTE_DATA;
                            n_shift_byte = r_data_byte;
                            n_phase      = PH_BIT_LOW;
                        end
                    end
                    BYTE_RADDR: begin
                        n_shift_byte = 8'd0;
                        n_phase      = PH_RD_LOW;
                    end
                    default: begin
                        n_phase = PH_STOP_LOW;
                    end
                endcase
            end
            PH_RS_LOW: begin
                scl     = 1'b0;
                n_phase = PH_RS_HIGH;
            end
            PH_RS_HIGH: begin
                n_phase = PH_RS_FALL;
            end
            PH_RS_FALL: begin
                sda          = 1'b0;
                n_byte_index = BYTE_RADDR;
                n_bit_count  = 3'd0;
                n_shift_byte = {i_cfg.device_address, 1'b1};
                n_phase      = PH_BIT_LOW;
            end
            PH_RD_LOW: begin
                scl     = 1'b0;
                n_phase = PH_RD_HIGH;
            end
            PH_RD_HIGH: begin
                n_shift_byte = {r_shift_byte[6:0], i_item.sda_in};
                if (r_bit_count == LAST_BIT) begin
                    n_bit_count     = 3'd0;
                    n_received_byte = {r_shift_byte[6:0], i_item.sda_in};
                    n_phase         = PH_NACK_LOW;
                end else begin
                    n_bit_count = r_bit_count + 3'd1;
                    n_phase     = PH_RD_LOW;
                end
            end
            PH_NACK_LOW: begin
                scl     = 1'b0;
                n_phase = PH_NACK_HIGH;
            end
            PH_NACK_HIGH: begin
                n_phase = PH_STOP_LOW;
            end
            PH_STOP_LOW: begin
                scl     = 1'b0;
                sda     = 1'b0;
                n_phase = PH_STOP_HIGH;
            end
            PH_STOP_HIGH: begin
                sda     = 1'b0;
                n_phase = PH_STOP_DONE;
            end
            PH_STOP_DONE: begin
                done    = 1'b1;
                n_phase = PH_IDLE;
            end
            default: begin
                busy    = 1'b0;
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_IDLE;
            r_bit_count     <= 3'd0;
            r_byte_index    <= BYTE_DEV;
            r_shift_byte    <= 8'd0;
            r_received_byte <= 8'd0;
            r_read_mode     <= 1'b0;
            r_ack_fault     <= 1'b0;
            r_data_byte     <= 8'd0;
        end else if (i_step) begin
            r_phase         <= n_phase;
            r_bit_count     <= n_bit_count;
            r_byte_index    <= n_byte_index;
            r_shift_byte    <= n_shift_byte;
            r_received_byte <= n_received_byte;
            r_read_mode     <= n_read_mode;
            r_ack_fault     <= n_ack_fault;
            r_data_byte     <= n_data_byte;
        end
    end

    always_comb begin
        o_result.scl       = scl;
        o_result.sda_out   = sda;
        o_result.busy_res  = busy;
        o_result.done_res  = done;
        o_result.read_data = n_received_byte;
        o_result.ack_error = n_ack_fault;
    end

endmodule

FILE: rtl/i2cm_out_stage.sv
// Result register of the I2C register-access master with valid/ready output.
// Depends on i2cm_pkg for the t_out_item struct.
module i2cm_out_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  i2cm_pkg::t_out_item i_result,
    output logic                o_can_load,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output i2cm_pkg::t_out_item o_out_item
);
    import i2cm_pkg::*;

    logic      r_valid;
    t_out_item r_item;

    assign o_can_load = !r_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_result;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_item  = r_item;

endmodule

FILE: rtl/i2cm_checker.sv
// Port-level checker for the I2C register-access master, bound to the top level.
// Depends on i2cm_pkg for the item structs.
module i2cm_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_ready,
    input i2cm_pkg::t_out_item o_out_item,
    input logic                o_out_valid,
    input logic                i_out_ready
);
    import i2cm_pkg::*;

    a_out_valid_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("Result item dropped while stalled.");

    a_out_item_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_item))
        else $error("Stalled result item changed.");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("Input stalled with an empty result register.");

    a_done_on_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.done_res |->
            o_out_item.busy_res && o_out_item.scl && o_out_item.sda_out)
        else $error("Done shown without a completed stop condition.");

    a_idle_lines: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.busy_res |->
            o_out_item.scl && o_out_item.sda_out && !o_out_item.done_res)
        else $error("Bus lines not released while idle.");

endmodule

bind i2c_master_register_access i2cm_checker u_i2cm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_item  (o_out_item),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready)
);

FILE: tb/i2c_master_register_access_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the I2C register-access master, driven one half-bit tick per item.
// A bus predictor in the testbench works out every tick's line levels and status for comparison.
// Depends on i2cm_pkg and the i2c_master_register_access top level.
module i2c_master_register_access_tb;
    import i2cm_pkg::*;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_SPARE = 2'd3;
    localparam int STALL_LIMIT = 2000;

    typedef enum {RX_ALWAYS, RX_COIN, RX_PERIODIC, RX_SPARSE} t_rx_pattern;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    t_in_item   i_in_item = '0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b1;
    t_out_item  o_out_item;
    logic       i_cfg_we = 1'b0;
    logic       i_cfg_index = 1'b0;
    logic [7:0] i_cfg_wdata = '0;

    t_phase     bus_phase;
    logic [2:0] bus_bit;
    logic [1:0] bus_byte;
    logic [7:0] bus_shift;
    logic [7:0] bus_rx_byte;
    logic [7:0] bus_data_byte;
    logic       bus_read;
    logic       bus_fault;
    logic [6:0] bus_dev_addr;
    logic [7:0] bus_reg_addr;

    t_out_item   tick_results[$];
    int          errors = 0;
    int          items_sent = 0;
    int          burst_left = 0;
    bit          sender_bursty = 1'b1;
    int          hold_request = 0;
    int          hold_left = 0;
    t_rx_pattern rx_pattern = RX_ALWAYS;
    int          rx_pattern_left = 0;
    int          rx_count = 0;
    int          idle_cycles = 0;

    i2c_master_register_access i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #2 i_clk = ~i_clk;

    function automatic void reset_bus_state();
        bus_phase     = PH_IDLE;
        bus_bit       = '0;
        bus_byte      = BYTE_DEV;
        bus_shift     = '0;
        bus_rx_byte   = '0;
        bus_data_byte = '0;
        bus_read      = 1'b0;
        bus_fault     = 1'b0;
        bus_dev_addr  = DEV_ADDR_RESET;
        bus_reg_addr  = REG_ADDR_RESET;
    endfunction

    function automatic t_out_item predict_tick(t_in_item it);
        t_out_item r;
        r          = '0;
        r.scl      = 1'b1;
        r.sda_out  = 1'b1;
        r.busy_res = 1'b1;
        case (bus_phase)
            PH_IDLE: begin
                if (it.cmd == CMD_WRITE || it.cmd == CMD_READ) begin
                    bus_read      = (it.cmd == CMD_READ);
                    bus_data_byte = it.write_value;
                    bus_fault     = 1'b0;
                    bus_byte      = BYTE_DEV;
                    bus_bit       = '0;
                    bus_shift     = {bus_dev_addr, 1'b0};
                    r.sda_out     = 1'b0;
                    bus_phase     = PH_BIT_LOW;
                end else begin
                    r.busy_res = 1'b0;
                end
            end
            PH_BIT_LOW: begin
                r.scl     = 1'b0;
                r.sda_out = bus_shift[LAST_BIT - bus_bit];
                bus_phase = PH_BIT_HIGH;
            end
            PH_BIT_HIGH: begin
                r.sda_out = bus_shift[LAST_BIT - bus_bit];
                if (bus_bit == LAST_BIT) begin
                    bus_bit   = '0;
                    bus_phase = PH_ACK_LOW;
                end else begin
                    bus_bit   = bus_bit + 3'd1;
                    bus_phase = PH_BIT_LOW;
                end
            end
            PH_ACK_LOW: begin
                r.scl     = 1'b0;
                bus_phase = PH_ACK_HIGH;
            end
            PH_ACK_HIGH: begin
                if (it.sda_in) begin
                    bus_fault = 1'b1;
                end
                bus_bit = '0;
                case (bus_byte)
                    BYTE_DEV: begin
                        bus_byte  = BYTE_REG;
                        bus_shift = bus_reg_addr;
                        bus_phase = PH_BIT_LOW;
                    end
                    BYTE_REG: begin
                        if (bus_read) begin
                            bus_phase = PH_RS_LOW;
                        end else begin
                            bus_byte  = BYTE_DATA;
                            bus_shift = bus_data_byte;
                            bus_phase = PH_BIT_LOW;
                        end
                    end
                    BYTE_RADDR: begin
                        bus_shift = '0;
                        bus_phase = PH_RD_LOW;
                    end
                    default: begin
                        bus_phase = PH_STOP_LOW;
                    end
                endcase
            end
            PH_RS_LOW: begin
                r.scl     = 1'b0;
                bus_phase = PH_RS_HIGH;
            end
            PH_RS_HIGH: begin
                bus_phase = PH_RS_FALL;
            end
            PH_RS_FALL: begin
                r.sda_out = 1'b0;
                bus_byte  = BYTE_RADDR;
                bus_bit   = '0;
                bus_shift = {bus_dev_addr, 1'b1};
                bus_phase = PH_BIT_LOW;
            end
            PH_RD_LOW: begin
                r.scl     = 1'b0;
                bus_phase = PH_RD_HIGH;
            end
            PH_RD_HIGH: begin
                bus_shift = {bus_shift[6:0], it.sda_in};
                if (bus_bit == LAST_BIT) begin
                    bus_bit     = '0;
                    bus_rx_byte = bus_shift;
                    bus_phase   = PH_NACK_LOW;
                end else begin
                    bus_bit   = bus_bit + 3'd1;
                    bus_phase = PH_RD_LOW;
                end
            end
            PH_NACK_LOW: begin
                r.scl     = 1'b0;
                bus_phase = PH_NACK_HIGH;
            end
            PH_NACK_HIGH: begin
                bus_phase = PH_STOP_LOW;
            end
            PH_STOP_LOW: begin
                r.scl     = 1'b0;
                r.sda_out = 1'b0;
                bus_phase = PH_STOP_HIGH;
            end
            PH_STOP_HIGH: begin
                r.sda_out = 1'b0;
                bus_phase = PH_STOP_DONE;
            end
            PH_STOP_DONE: begin
                r.done_res = 1'b1;
                bus_phase  = PH_IDLE;
            end
            default: begin
                r.busy_res = 1'b0;
                bus_phase  = PH_IDLE;
            end
        endcase
        r.read_data = bus_rx_byte;
        r.ack_error = bus_fault;
        return r;
    endfunction

    task automatic write_register(logic idx, logic [7:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_DEVICE_ADDRESS) begin
            bus_dev_addr = value[6:0];
        end else begin
            bus_reg_addr = value;
        end
    endtask

    task automatic send_tick(t_in_item it);
        int gap;
        if (sender_bursty && burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        if (burst_left > 0) begin
            burst_left--;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        tick_results.push_back(predict_tick(it));
        items_sent++;
    endtask

    task automatic wait_for_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (tick_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic send_bus_tick(int nack_pct);
        t_in_item it;
        it.cmd         = 2'($urandom_range(0, 3));
        it.write_value = 8'($urandom);
        if (bus_phase == PH_ACK_HIGH) begin
            it.sda_in = ($urandom_range(0, 99) < nack_pct);
        end else begin
            it.sda_in = 1'($urandom_range(0, 1));
        end
        send_tick(it);
    endtask

    task automatic start_transaction(logic [1:0] cmd, logic [7:0] value);
        t_in_item it;
        it.cmd         = cmd;
        it.write_value = value;
        it.sda_in      = 1'($urandom_range(0, 1));
        send_tick(it);
    endtask

    task automatic finish_transaction(int nack_pct);
        while (bus_phase != PH_IDLE) begin
            send_bus_tick(nack_pct);
        end
    endtask

    task automatic run_transaction(logic [1:0] cmd, logic [7:0] value, int nack_pct);
        start_transaction(cmd, value);
        finish_transaction(nack_pct);
    endtask

    task automatic test_reset_defaults();
        send_tick('{CMD_TICK, 8'hFF, 1'b1});
        send_tick('{CMD_SPARE, 8'h00, 1'b0});
        send_tick('{CMD_SPARE, 8'hFF, 1'b1});
        send_tick('{CMD_TICK, 8'h00, 1'b0});
        run_transaction(CMD_READ, 8'h00, 0);
        wait_for_results();
    endtask

    task automatic test_write_extremes();
        write_register(CFG_DEVICE_ADDRESS, 8'hFF);
        write_register(CFG_REGISTER_ADDRESS, 8'hFF);
        run_transaction(CMD_WRITE, 8'hFF, 100);
        run_transaction(CMD_WRITE, 8'h00, 0);
        wait_for_results();
    endtask

    task automatic test_read_extremes();
        write_register(CFG_DEVICE_ADDRESS, 8'h80);
        write_register(CFG_REGISTER_ADDRESS, 8'h00);
        run_transaction(CMD_READ, 8'hA5, 100);
        run_transaction(CMD_READ, 8'($urandom), 0);
        wait_for_results();
    endtask

    task automatic test_config_midway();
        write_register(CFG_DEVICE_ADDRESS, 8'h2A);
        write_register(CFG_REGISTER_ADDRESS, 8'h11);
        start_transaction(CMD_WRITE, 8'($urandom));
        repeat (10) send_bus_tick(0);
        wait_for_results();
        write_register(CFG_REGISTER_ADDRESS, 8'hC3);
        finish_transaction(0);
        start_transaction(CMD_READ, 8'($urandom));
        repeat (30) send_bus_tick(0);
        wait_for_results();
        write_register(CFG_DEVICE_ADDRESS, 8'h55);
        finish_transaction(0);
        wait_for_results();
    endtask

    task automatic test_backpressure();
        sender_bursty = 1'b0;
        hold_request  = 150;
        run_transaction(CMD_READ, 8'($urandom), 10);
        run_transaction(CMD_WRITE, 8'($urandom), 10);
        wait_for_results();
        sender_bursty = 1'b1;
    endtask

    task automatic test_random_traffic();
        int target;
        for (int round = 0; round < 4; round++) begin
            case (round)
                0: begin
                    write_register(CFG_DEVICE_ADDRESS, 8'h00);
                    write_register(CFG_REGISTER_ADDRESS, 8'hFF);
                end
                1: begin
                    write_register(CFG_DEVICE_ADDRESS, 8'h7F);
                    write_register(CFG_REGISTER_ADDRESS, 8'h00);
                end
                default: begin
                    write_register(CFG_DEVICE_ADDRESS, 8'($urandom));
                    write_register(CFG_REGISTER_ADDRESS, 8'($urandom));
                end
            endcase
            target = items_sent + 270;
            while (items_sent < target) begin
                if ($urandom_range(0, 5) == 0) begin
                    repeat ($urandom_range(1, 5)) begin
                        send_tick('{$urandom_range(0, 1) ? CMD_SPARE : CMD_TICK,
                                    8'($urandom), 1'($urandom)});
                    end
                end
                run_transaction($urandom_range(0, 1) ? CMD_WRITE : CMD_READ, 8'($urandom),
                                ($urandom_range(0, 7) == 0) ? 50 : 3);
            end
            wait_for_results();
        end
    endtask

    always @(negedge i_clk) begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (rx_pattern_left == 0) begin
            rx_pattern      = t_rx_pattern'($urandom_range(0, 3));
            rx_pattern_left = $urandom_range(64, 256);
        end
        rx_pattern_left--;
        rx_count++;
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            case (rx_pattern)
                RX_ALWAYS:   i_out_ready <= 1'b1;
                RX_COIN:     i_out_ready <= 1'($urandom_range(0, 1));
                RX_PERIODIC: i_out_ready <= (rx_count % 4 != 0);
                default:     i_out_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (tick_results.size() == 0) begin
                $error("unexpected result %h", o_out_item);
                errors++;
            end else begin
                want = tick_results.pop_front();
                if (o_out_item.scl !== want.scl) begin
                    $error("scl: expected %0d, got %0d", want.scl, o_out_item.scl);
                    errors++;
                end
                if (o_out_item.sda_out !== want.sda_out) begin
                    $error("sda_out: expected %0d, got %0d", want.sda_out, o_out_item.sda_out);
                    errors++;
                end
                if (o_out_item.busy_res !== want.busy_res) begin
                    $error("busy_res: expected %0d, got %0d", want.busy_res,
                           o_out_item.busy_res);
                    errors++;
                end
                if (o_out_item.done_res !== want.done_res) begin
                    $error("done_res: expected %0d, got %0d", want.done_res,
                           o_out_item.done_res);
                    errors++;
                end
                if (o_out_item.read_data !== want.read_data) begin
                    $error("read_data: expected %h, got %h", want.read_data,
                           o_out_item.read_data);
                    errors++;
                end
                if (o_out_item.ack_error !== want.ack_error) begin
                    $error("ack_error: expected %0d, got %0d", want.ack_error,
                           o_out_item.ack_error);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles = 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles++;
        end
    end

    initial begin
        reset_bus_state();
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_write_extremes();
        test_read_extremes();
        test_config_midway();
        test_backpressure();
        test_random_traffic();
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

FILE: i2c_master_register_access.f
rtl/i2cm_pkg.sv
rtl/i2cm_cfg_regs.sv
rtl/i2cm_fsm.sv
rtl/i2cm_out_stage.sv
rtl/i2c_master_register_access.sv
rtl/i2cm_checker.sv
tb/i2c_master_register_access_tb.sv
